[hw/rtl/drrc_pkg.sv]
// ----------------------------------------------------------------------------
// drrc_pkg: shared definitions of the dirty rectangle repaint coalescer
// Command codes, configuration register indexes and reset values that the
// coalescer modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package drrc_pkg;

    // Command field of an input transaction.
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_RECT = 2'd0;
    localparam t_cmd CMD_TICK = 2'd1;
    localparam t_cmd CMD_MODE = 2'd2;
    localparam t_cmd CMD_NONE = 2'd3;

    // Configuration registers are all 16 bits wide.
    localparam int CFG_W = 16;

    typedef logic [CFG_W-1:0] t_cfg_data;
    typedef logic             t_cfg_index;

    localparam t_cfg_index CFG_STD_DELAY  = 1'b0;
    localparam t_cfg_index CFG_FAST_DELAY = 1'b1;

    localparam t_cfg_data STD_DELAY_RESET  = 16'd400;
    localparam t_cfg_data FAST_DELAY_RESET = 16'd50;

endpackage

`default_nettype wire

[hw/rtl/drrc_in_stage.sv]
// ----------------------------------------------------------------------------
// drrc_in_stage: input register of the coalescer
// Captures one input transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module drrc_in_stage #(
    parameter int COORD_BITS = 12
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  drrc_pkg::t_cmd   i_cmd,
    input  wire  [COORD_BITS-1:0]  i_rect_x,
    input  wire  [COORD_BITS-1:0]  i_rect_y,
    input  wire  [COORD_BITS:0]    i_rect_w,
    input  wire  [COORD_BITS:0]    i_rect_h,
    input  wire                    i_fast_select,
    input  wire                    i_take,
    output logic                   o_valid,
    output drrc_pkg::t_cmd         o_cmd,
    output logic [COORD_BITS-1:0]  o_rect_x,
    output logic [COORD_BITS-1:0]  o_rect_y,
    output logic [COORD_BITS:0]    o_rect_w,
    output logic [COORD_BITS:0]    o_rect_h,
    output logic                   o_fast_select
);

    logic                  r_valid;
    logic                  n_valid;
    logic                  w_load;
    drrc_pkg::t_cmd        r_cmd;
    logic [COORD_BITS-1:0] r_rect_x;
    logic [COORD_BITS-1:0] r_rect_y;
    logic [COORD_BITS:0]   r_rect_w;
    logic [COORD_BITS:0]   r_rect_h;
    logic                  r_fast_select;

    // The register refills in the same cycle that the core drains it.
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_comb begin
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset; it is only used while the valid flag is set.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd         <= i_cmd;
            r_rect_x      <= i_rect_x;
            r_rect_y      <= i_rect_y;
            r_rect_w      <= i_rect_w;
            r_rect_h      <= i_rect_h;
            r_fast_select <= i_fast_select;
        end
    end

    assign o_valid       = r_valid;
    assign o_cmd         = r_cmd;
    assign o_rect_x      = r_rect_x;
    assign o_rect_y      = r_rect_y;
    assign o_rect_w      = r_rect_w;
    assign o_rect_h      = r_rect_h;
    assign o_fast_select = r_fast_select;

endmodule

`default_nettype wire

[hw/rtl/drrc_core.sv]
// ----------------------------------------------------------------------------
// drrc_core: box merge, repaint timer and repaint decision
// Holds the pending box, the mode and the tick counter, and decides for each
// transaction whether a repaint command is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module drrc_core #(
    parameter int COORD_BITS = 12,
    parameter int TIMER_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire                        i_take,
    input  wire  drrc_pkg::t_cmd       i_cmd,
    input  wire  [COORD_BITS-1:0]      i_rect_x,
    input  wire  [COORD_BITS-1:0]      i_rect_y,
    input  wire  [COORD_BITS:0]        i_rect_w,
    input  wire  [COORD_BITS:0]        i_rect_h,
    input  wire                        i_fast_select,
    input  wire  drrc_pkg::t_cfg_data  i_std_delay,
    input  wire  drrc_pkg::t_cfg_data  i_fast_delay,
    output logic                       o_fire,
    output logic [COORD_BITS-1:0]      o_x,
    output logic [COORD_BITS-1:0]      o_y,
    output logic [COORD_BITS:0]        o_w,
    output logic [COORD_BITS:0]        o_h,
    output logic                       o_fast
);

    localparam int SUM_W = COORD_BITS + 2;
    localparam int CMP_W = TIMER_BITS + drrc_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic                  r_pending;
    logic                  r_fast_mode;
    logic [TIMER_BITS-1:0] r_since;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [COORD_BITS:0]   r_pw;
    logic [COORD_BITS:0]   r_ph;

    logic                  n_pending;
    logic                  n_fast_mode;
    logic [TIMER_BITS-1:0] n_since;
    logic [COORD_BITS-1:0] n_px;
    logic [COORD_BITS-1:0] n_py;
    logic [COORD_BITS:0]   n_pw;
    logic [COORD_BITS:0]   n_ph;

    logic                  w_step;
    logic [COORD_BITS-1:0] w_left;
    logic [COORD_BITS-1:0] w_top;
    logic [SUM_W-1:0]      w_right;
    logic [SUM_W-1:0]      w_bottom;
    logic [SUM_W-1:0]      w_r0;
    logic [SUM_W-1:0]      w_b0;
    logic [SUM_W-1:0]      w_mw;
    logic [SUM_W-1:0]      w_mh;
    logic                  w_mrg_pending;
    logic                  w_mrg_fast;
    logic [TIMER_BITS-1:0] w_mrg_since;
    logic [COORD_BITS-1:0] w_mrg_x;
    logic [COORD_BITS-1:0] w_mrg_y;
    logic [COORD_BITS:0]   w_mrg_w;
    logic [COORD_BITS:0]   w_mrg_h;
    drrc_pkg::t_cfg_data   w_delay;
    logic                  w_fire;

    assign w_step = i_valid && i_take;

    // Bounding box of the pending box and the new rectangle.
    always_comb begin
        w_left   = (i_rect_x < r_px) ? i_rect_x : r_px;
        w_top    = (i_rect_y < r_py) ? i_rect_y : r_py;
        w_right  = SUM_W'(i_rect_x) + SUM_W'(i_rect_w);
        w_r0     = SUM_W'(r_px) + SUM_W'(r_pw);
        w_bottom = SUM_W'(i_rect_y) + SUM_W'(i_rect_h);
        w_b0     = SUM_W'(r_py) + SUM_W'(r_ph);
        if (w_r0 > w_right) begin
            w_right = w_r0;
        end
        if (w_b0 > w_bottom) begin
            w_bottom = w_b0;
        end
        w_mw = w_right - SUM_W'(w_left);
        w_mh = w_bottom - SUM_W'(w_top);
    end

    // State after the command itself, before the repaint check.
    always_comb begin
        w_mrg_pending = r_pending;
        w_mrg_fast    = r_fast_mode;
        w_mrg_since   = r_since;
        w_mrg_x       = r_px;
        w_mrg_y       = r_py;
        w_mrg_w       = r_pw;
        w_mrg_h       = r_ph;
        case (i_cmd)
            drrc_pkg::CMD_RECT: begin
                w_mrg_pending = 1'b1;
                if (r_pending) begin
                    w_mrg_x = w_left;
                    w_mrg_y = w_top;
                    w_mrg_w = w_mw[COORD_BITS:0];
                    w_mrg_h = w_mh[COORD_BITS:0];
                end else begin
                    w_mrg_x = i_rect_x;
                    w_mrg_y = i_rect_y;
                    w_mrg_w = i_rect_w;
                    w_mrg_h = i_rect_h;
                end
            end
            drrc_pkg::CMD_TICK: begin
                if (r_since != TIMER_MAX) begin
                    w_mrg_since = r_since + 1'b1;
                end
            end
            drrc_pkg::CMD_MODE: begin
                w_mrg_fast = i_fast_select;
            end
            default: begin
            end
        endcase
    end

    // Repaint check against the delay of the mode now in force.
    always_comb begin
        w_delay = w_mrg_fast ? i_fast_delay : i_std_delay;
        w_fire  = w_step && w_mrg_pending && (CMP_W'(w_mrg_since) >= CMP_W'(w_delay));
    end

    always_comb begin
        n_pending   = r_pending;
        n_fast_mode = r_fast_mode;
        n_since     = r_since;
        n_px        = r_px;
        n_py        = r_py;
        n_pw        = r_pw;
        n_ph        = r_ph;
        if (w_step) begin
            n_pending   = w_mrg_pending;
            n_fast_mode = w_mrg_fast;
            n_since     = w_mrg_since;
            n_px        = w_mrg_x;
            n_py        = w_mrg_y;
            n_pw        = w_mrg_w;
            n_ph        = w_mrg_h;
            if (w_fire) begin
                n_since = '0;
                if (!w_mrg_fast) begin
                    n_pending = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_fast_mode <= 1'b0;
            r_since     <= TIMER_MAX;
            r_px        <= '0;
            r_py        <= '0;
            r_pw        <= '0;
            r_ph        <= '0;
        end else begin
            r_pending   <= n_pending;
            r_fast_mode <= n_fast_mode;
            r_since     <= n_since;
            r_px        <= n_px;
            r_py        <= n_py;
            r_pw        <= n_pw;
            r_ph        <= n_ph;
        end
    end

    assign o_fire = w_fire;
    assign o_x    = w_mrg_x;
    assign o_y    = w_mrg_y;
    assign o_w    = w_mrg_w;
    assign o_h    = w_mrg_h;
    assign o_fast = w_mrg_fast;

endmodule

`default_nettype wire

[hw/rtl/dirty_rect_repaint_coalescer.sv]
// ----------------------------------------------------------------------------
// dirty_rect_repaint_coalescer: merges damaged rectangles into repaint commands
// Top level with configuration registers, input stage, core and result
// register.
// ----------------------------------------------------------------------------
// Each transaction (rectangle, tick or mode change) is handled in the
// core and the block accepts one transaction per clock as long as repaint
// commands are taken. A transaction passes through the input register and,
// if it triggers a repaint when the core takes it, the command is loaded
// into the result register. The rate is set by the combinational merge and
// timer compare in the core; when the output is stalled, one more
// transaction is held in the input register before input stall rises.
// Delay registers should be written while the block is idle.
`default_nettype none

module dirty_rect_repaint_coalescer #(
    parameter int COORD_BITS = 12,
    parameter int TIMER_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // Configuration write port
    input  wire                        i_cfg_we,
    input  wire  drrc_pkg::t_cfg_index i_cfg_index,
    input  wire  drrc_pkg::t_cfg_data  i_cfg_data,
    // Input channel
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire  drrc_pkg::t_cmd       i_cmd,
    input  wire  [COORD_BITS-1:0]      i_rect_x,
    input  wire  [COORD_BITS-1:0]      i_rect_y,
    input  wire  [COORD_BITS:0]        i_rect_w,
    input  wire  [COORD_BITS:0]        i_rect_h,
    input  wire                        i_fast_select,
    // Output channel
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [COORD_BITS-1:0]      o_repaint_x,
    output logic [COORD_BITS-1:0]      o_repaint_y,
    output logic [COORD_BITS:0]        o_repaint_w,
    output logic [COORD_BITS:0]        o_repaint_h,
    output logic                       o_waveform_fast
);

    drrc_pkg::t_cfg_data   r_std_delay;
    drrc_pkg::t_cfg_data   r_fast_delay;

    logic                  w_stg_valid;
    drrc_pkg::t_cmd        w_stg_cmd;
    logic [COORD_BITS-1:0] w_stg_x;
    logic [COORD_BITS-1:0] w_stg_y;
    logic [COORD_BITS:0]   w_stg_w;
    logic [COORD_BITS:0]   w_stg_h;
    logic                  w_stg_fast_select;
    logic                  w_take;

    logic                  w_fire;
    logic [COORD_BITS-1:0] w_x;
    logic [COORD_BITS-1:0] w_y;
    logic [COORD_BITS:0]   w_w;
    logic [COORD_BITS:0]   w_h;
    logic                  w_fast;

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [COORD_BITS:0]   r_out_w;
    logic [COORD_BITS:0]   r_out_h;
    logic                  r_out_fast;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std_delay  <= drrc_pkg::STD_DELAY_RESET;
            r_fast_delay <= drrc_pkg::FAST_DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drrc_pkg::CFG_STD_DELAY:  r_std_delay  <= i_cfg_data;
                drrc_pkg::CFG_FAST_DELAY: r_fast_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The core takes a transaction whenever the result register has room.
    assign w_take = !r_out_valid || !i_out_stall;

    drrc_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_w      (i_rect_w),
        .i_rect_h      (i_rect_h),
        .i_fast_select (i_fast_select),
        .i_take        (w_take),
        .o_valid       (w_stg_valid),
        .o_cmd         (w_stg_cmd),
        .o_rect_x      (w_stg_x),
        .o_rect_y      (w_stg_y),
        .o_rect_w      (w_stg_w),
        .o_rect_h      (w_stg_h),
        .o_fast_select (w_stg_fast_select)
    );

    drrc_core #(
        .COORD_BITS (COORD_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_stg_valid),
        .i_take        (w_take),
        .i_cmd         (w_stg_cmd),
        .i_rect_x      (w_stg_x),
        .i_rect_y      (w_stg_y),
        .i_rect_w      (w_stg_w),
        .i_rect_h      (w_stg_h),
        .i_fast_select (w_stg_fast_select),
        .i_std_delay   (r_std_delay),
        .i_fast_delay  (r_fast_delay),
        .o_fire        (w_fire),
        .o_x           (w_x),
        .o_y           (w_y),
        .o_w           (w_w),
        .o_h           (w_h),
        .o_fast        (w_fast)
    );

    // Result register: loads a repaint command, drops when it is taken.
    always_comb begin
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_x    <= w_x;
            r_out_y    <= w_y;
            r_out_w    <= w_w;
            r_out_h    <= w_h;
            r_out_fast <= w_fast;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_repaint_x     = r_out_x;
    assign o_repaint_y     = r_out_y;
    assign o_repaint_w     = r_out_w;
    assign o_repaint_h     = r_out_h;
    assign o_waveform_fast = r_out_fast;

`ifndef SYNTHESIS
    // Input stall only rises behind a stalled, full result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while the result register could drain");

    // A repaint is only issued for a transaction the core actually consumes.
    a_fire_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (w_stg_valid && w_take))
        else $error("repaint issued without a consumed transaction");

    // A new result only appears after the core issued a repaint.
    a_out_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_fire))
        else $error("output valid rose without a repaint decision");
`endif

endmodule

`default_nettype wire
